// File: hdl/i2crm_pkg.sv
// shared types and constants for the i2c register master
package i2crm_pkg;

  localparam int unsigned OpcodeW   = 2;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned PhaseW    = 16;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned InDataW   = 32;
  localparam int unsigned OutDataW  = 16;

  // command codes carried in the opcode field
  localparam logic [OpcodeW-1:0] OP_TICK  = 2'd0;
  localparam logic [OpcodeW-1:0] OP_WRITE = 2'd1;
  localparam logic [OpcodeW-1:0] OP_READ  = 2'd2;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] CFG_DEV_ADDR    = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_ACK_TIMEOUT = 2'd1;
  localparam logic [CfgIndexW-1:0] CFG_PHASE_TICKS = 2'd2;

  localparam logic [ByteW-1:0]  DEV_ADDR_RESET    = 8'd76;
  localparam logic [ByteW-1:0]  ACK_TIMEOUT_RESET = 8'd250;
  localparam logic [PhaseW-1:0] PHASE_TICKS_RESET = 16'd1;

  typedef struct packed {
    logic [ByteW-1:0]  dev_addr;
    logic [ByteW-1:0]  ack_timeout;
    logic [PhaseW-1:0] phase_ticks;
  } cfg_t;

  typedef struct packed {
    logic [OpcodeW-1:0] opcode;
    logic [ByteW-1:0]   reg_address;
    logic [ByteW-1:0]   write_byte;
    logic [ByteW-1:0]   read_count;
    logic               sda_sample;
  } cmd_t;

  typedef struct packed {
    logic             scl_level;
    logic             sda_release;
    logic             busy_res;
    logic [ByteW-1:0] read_byte;
    logic             read_valid;
    logic             read_last;
    logic             done_res;
    logic             nack_error;
  } res_t;

endpackage

// File: hdl/i2crm_seq.sv
// bus sequencer: one tick per accepted beat, produces the line levels and status
module i2crm_seq import i2crm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic accept,
  input  cmd_t cmd,
  output res_t res
);

  typedef enum logic [15:0] {
    ST_IDLE      = 16'h0001,
    ST_START_A   = 16'h0002,
    ST_START_B   = 16'h0004,
    ST_TX_LOW    = 16'h0008,
    ST_TX_HIGH   = 16'h0010,
    ST_ACK_LOW   = 16'h0020,
    ST_ACK_HIGH  = 16'h0040,
    ST_ACK_POLL  = 16'h0080,
    ST_RS_SETUP  = 16'h0100,
    ST_RX_LOW    = 16'h0200,
    ST_RX_HIGH   = 16'h0400,
    ST_MACK_LOW  = 16'h0800,
    ST_MACK_HIGH = 16'h1000,
    ST_STOP_A    = 16'h2000,
    ST_STOP_B    = 16'h4000,
    ST_STOP_C    = 16'h8000
  } phase_t;

  typedef struct packed {
    phase_t            phase;
    logic [2:0]        bit_cnt;
    logic [ByteW-1:0]  shreg;
    logic [PhaseW-1:0] timer;
    logic [ByteW-1:0]  ack_cnt;
    logic [ByteW-1:0]  bytes_left;
    logic              lc_read;
    logic [ByteW-1:0]  lc_reg;
    logic [ByteW-1:0]  lc_data;
    logic              err;
    logic [1:0]        byte_stage;
  } seq_state_t;

  // idle with every counter and latch cleared
  localparam seq_state_t SEQ_RESET = '{
    phase: ST_IDLE, bit_cnt: '0, shreg: '0, timer: '0, ack_cnt: '0, bytes_left: '0,
    lc_read: 1'b0, lc_reg: '0, lc_data: '0, err: 1'b0, byte_stage: '0
  };

  seq_state_t        cur;
  seq_state_t        cur_next;
  logic [PhaseW-1:0] phase_len;
  logic [PhaseW:0]   tmr_inc;
  logic              phase_end;
  logic [ByteW-1:0]  bytes_dec;
  logic              last_byte;

  always_comb begin
    phase_len = (cfg.phase_ticks == '0) ? PhaseW'(1) : cfg.phase_ticks;
    tmr_inc   = {1'b0, cur.timer} + (PhaseW+1)'(1);
    phase_end = tmr_inc >= {1'b0, phase_len};
    bytes_dec = cur.bytes_left - ByteW'(1);
    last_byte = cur.bytes_left == ByteW'(1);
  end

  always_comb begin
    cur_next = cur;
    res = '0;
    res.scl_level   = 1'b1;
    res.sda_release = 1'b1;
    res.busy_res    = cur.phase != ST_IDLE;

    // line levels for this tick
    case (cur.phase)
      ST_START_B: res.sda_release = 1'b0;
      ST_TX_LOW: begin
        res.scl_level   = 1'b0;
        res.sda_release = cur.shreg[ByteW-1];
      end
      ST_TX_HIGH: res.sda_release = cur.shreg[ByteW-1];
      ST_ACK_LOW, ST_RS_SETUP, ST_RX_LOW: res.scl_level = 1'b0;
      ST_MACK_LOW: begin
        res.scl_level   = 1'b0;
        res.sda_release = last_byte;
      end
      ST_MACK_HIGH: res.sda_release = last_byte;
      ST_STOP_A: begin
        res.scl_level   = 1'b0;
        res.sda_release = 1'b0;
      end
      ST_STOP_B: res.sda_release = 1'b0;
      default: ;
    endcase

    // timed phases count here; a phase change leaves the timer at zero
    if (cur.phase != ST_IDLE && cur.phase != ST_ACK_POLL) begin
      cur_next.timer = phase_end ? '0 : tmr_inc[PhaseW-1:0];
    end

    case (cur.phase)
      ST_IDLE: begin
        if (cmd.opcode == OP_WRITE || cmd.opcode == OP_READ) begin
          cur_next.lc_read    = cmd.opcode == OP_READ;
          cur_next.lc_reg     = cmd.reg_address;
          cur_next.lc_data    = cmd.write_byte;
          cur_next.bytes_left = cmd.read_count;
          cur_next.err        = 1'b0;
          cur_next.byte_stage = 2'd0;
          cur_next.bit_cnt    = '0;
          cur_next.ack_cnt    = '0;
          cur_next.shreg      = cfg.dev_addr;
          cur_next.timer      = '0;
          cur_next.phase      = ST_START_A;
        end
      end
      ST_START_A: if (phase_end) cur_next.phase = ST_START_B;
      ST_START_B: begin
        if (phase_end) begin
          cur_next.bit_cnt = '0;
          cur_next.phase   = ST_TX_LOW;
        end
      end
      ST_TX_LOW: if (phase_end) cur_next.phase = ST_TX_HIGH;
      ST_TX_HIGH: begin
        if (phase_end) begin
          cur_next.shreg = {cur.shreg[ByteW-2:0], 1'b0};
          if (cur.bit_cnt == 3'd7) begin
            cur_next.bit_cnt = '0;
            cur_next.ack_cnt = '0;
            cur_next.phase   = ST_ACK_LOW;
          end else begin
            cur_next.bit_cnt = cur.bit_cnt + 3'd1;
            cur_next.phase   = ST_TX_LOW;
          end
        end
      end
      ST_ACK_LOW:  if (phase_end) cur_next.phase = ST_ACK_HIGH;
      ST_ACK_HIGH: if (phase_end) cur_next.phase = ST_ACK_POLL;
      ST_ACK_POLL: begin
        cur_next.timer = '0;
        if (!cmd.sda_sample) begin
          cur_next.bit_cnt = '0;
          if (cur.byte_stage == 2'd0) begin
            cur_next.byte_stage = 2'd1;
            cur_next.shreg      = cur.lc_reg;
            cur_next.phase      = ST_TX_LOW;
          end else if (cur.byte_stage == 2'd1) begin
            cur_next.byte_stage = 2'd2;
            if (cur.lc_read) begin
              cur_next.shreg = cfg.dev_addr | ByteW'(1);
              cur_next.phase = ST_RS_SETUP;
            end else begin
              cur_next.shreg = cur.lc_data;
              cur_next.phase = ST_TX_LOW;
            end
          end else if (cur.lc_read && cur.bytes_left != '0) begin
            cur_next.shreg = '0;
            cur_next.phase = ST_RX_LOW;
          end else begin
            cur_next.phase = ST_STOP_A;
          end
        end else if (cur.ack_cnt >= cfg.ack_timeout) begin
          cur_next.err   = 1'b1;
          cur_next.phase = ST_STOP_A;
        end else begin
          cur_next.ack_cnt = cur.ack_cnt + ByteW'(1);
        end
      end
      ST_RS_SETUP: if (phase_end) cur_next.phase = ST_START_A;
      ST_RX_LOW:   if (phase_end) cur_next.phase = ST_RX_HIGH;
      ST_RX_HIGH: begin
        if (phase_end) begin
          cur_next.shreg = {cur.shreg[ByteW-2:0], cmd.sda_sample};
          if (cur.bit_cnt == 3'd7) begin
            res.read_byte    = cur_next.shreg;
            res.read_valid   = 1'b1;
            res.read_last    = last_byte;
            cur_next.bit_cnt = '0;
            cur_next.phase   = ST_MACK_LOW;
          end else begin
            cur_next.bit_cnt = cur.bit_cnt + 3'd1;
            cur_next.phase   = ST_RX_LOW;
          end
        end
      end
      ST_MACK_LOW: if (phase_end) cur_next.phase = ST_MACK_HIGH;
      ST_MACK_HIGH: begin
        if (phase_end) begin
          cur_next.bytes_left = bytes_dec;
          cur_next.shreg      = '0;
          cur_next.phase      = (bytes_dec == '0) ? ST_STOP_A : ST_RX_LOW;
        end
      end
      ST_STOP_A: if (phase_end) cur_next.phase = ST_STOP_B;
      ST_STOP_B: if (phase_end) cur_next.phase = ST_STOP_C;
      ST_STOP_C: begin
        if (phase_end) begin
          res.done_res   = 1'b1;
          res.nack_error = cur.err;
          cur_next.phase = ST_IDLE;
        end
      end
      default: begin
        cur_next.timer = '0;
        cur_next.phase = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= SEQ_RESET;
    end else if (accept) begin
      cur <= cur_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && res.done_res) |=> cur.phase == ST_IDLE)
    else $error("stop finished but sequencer not idle");
  a_byte_to_mack: assert property (@(posedge clk) disable iff (rst)
    (accept && res.read_valid) |=> cur.phase == ST_MACK_LOW)
    else $error("received byte not followed by master ack");
  a_nack_with_done: assert property (@(posedge clk) disable iff (rst)
    res.nack_error |-> res.done_res)
    else $error("nack error flagged without done");
`endif

endmodule

// File: hdl/i2crm_obuf.sv
// two-entry result buffer: output register plus skid stage
module i2crm_obuf import i2crm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_data,
  output logic ready,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  logic main_valid;
  logic skid_valid;
  res_t main_data;
  res_t skid_data;
  logic pop;

  assign pop       = main_valid && out_ready;
  assign ready     = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (!main_valid) begin
      main_valid <= push;
    end else if (!pop && push) begin
      skid_valid <= 1'b1;
    end else if (pop && !push) begin
      main_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_data <= skid_data;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry held while output register empty");
  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !pop) |=> skid_valid && $stable(skid_data))
    else $error("skid entry lost while stalled");
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (push && !main_valid) |=> main_valid)
    else $error("beat pushed into empty buffer was dropped");
`endif

endmodule

// File: hdl/i2c_register_master.sv
// top level of the i2c register master: config registers, sequencer, result buffer
//
// each input beat on s_axis is one bus tick: the sampled sda level and, while
// idle, an optional command (write or read of a slave register). every
// accepted beat yields exactly one result beat on m_axis with the scl and sda
// levels to drive for that tick, busy, received bytes and the done / nack
// status. m_axis_tlast marks the final, nacked byte of a read.
// a result is registered in the result buffer when its input beat is accepted
// and shows on m_axis from there. throughput: one beat per cycle while
// s_axis_tready is high; the sequencer state updates once per accepted beat.
// a two-entry result buffer lets the block keep taking beats while one result
// waits; s_axis_tready drops only when both entries are full, so a stalled
// receiver stalls the bus clock with it and nothing is lost.
// the user must write config (device address, ack timeout, ticks per phase)
// via cfg_we / cfg_index / cfg_data only while idle; the block does not check.
// reset (rst, synchronous) returns the sequencer to idle, empties the buffer
// and loads the config defaults: address 76, timeout 250, one tick per phase.
module i2c_register_master import i2crm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // opcode[1:0], reg_address[9:2], write_byte[17:10], read_count[25:18],
  // sda_sample[26], zero pad above
  input  logic [InDataW-1:0]   s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // scl_level[0], sda_release[1], busy_res[2], read_byte[10:3],
  // read_valid[11], done_res[12], nack_error[13], zero pad above
  output logic [OutDataW-1:0]  m_axis_tdata,
  output logic                 m_axis_tlast,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  cfg_t cfg;
  cmd_t cmd;
  res_t res;
  res_t out_res;
  logic accept;

  // config registers, writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dev_addr    <= DEV_ADDR_RESET;
      cfg.ack_timeout <= ACK_TIMEOUT_RESET;
      cfg.phase_ticks <= PHASE_TICKS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEV_ADDR:    cfg.dev_addr    <= cfg_data[ByteW-1:0];
        CFG_ACK_TIMEOUT: cfg.ack_timeout <= cfg_data[ByteW-1:0];
        CFG_PHASE_TICKS: cfg.phase_ticks <= cfg_data[PhaseW-1:0];
        default: ;
      endcase
    end
  end

  // unpack the input beat
  assign cmd.opcode      = s_axis_tdata[1:0];
  assign cmd.reg_address = s_axis_tdata[9:2];
  assign cmd.write_byte  = s_axis_tdata[17:10];
  assign cmd.read_count  = s_axis_tdata[25:18];
  assign cmd.sda_sample  = s_axis_tdata[26];

  assign accept = s_axis_tvalid && s_axis_tready;

  i2crm_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (accept),
    .cmd    (cmd),
    .res    (res)
  );

  i2crm_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res),
    .ready     (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  // pack the result beat
  assign m_axis_tdata = {2'b00, out_res.nack_error, out_res.done_res, out_res.read_valid,
                         out_res.read_byte, out_res.busy_res, out_res.sda_release,
                         out_res.scl_level};
  assign m_axis_tlast = out_res.read_last;

endmodule
